// File: hdl/ipd_pkg.sv
package ipd_pkg;

	localparam int BUF_DEPTH_DEF = 64;
	localparam int BYTE_W        = 8;
	localparam int TAIL_BYTES    = 7;
	localparam int TAIL_W        = TAIL_BYTES * BYTE_W;
	localparam int TAIL_CNT_W    = 3;

	localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_I    = 8'h49;
	localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
	localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

	// Markers that clear the store, newest byte lowest
	localparam logic [7*BYTE_W-1:0] MARK_CONNECT = 56'h434F4E4E454354;
	localparam logic [6*BYTE_W-1:0] MARK_CLOSED  = 48'h434C4F534544;
	localparam logic [4*BYTE_W-1:0] MARK_IPD     = 32'h2B495044;

	// Prefix hunt and packet read mode
	typedef enum logic [4:0] {
		H_PLUS = 5'b00001,
		H_I    = 5'b00010,
		H_P    = 5'b00100,
		H_D    = 5'b01000,
		H_READ = 5'b10000
	} hunt_mode_t;

	// Flush sequencer
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD    = 4'b0010,
		S_LD    = 4'b0100,
		S_EMPTY = 4'b1000
	} seq_state_t;

	// Tail history control
	typedef struct packed {
		logic shift;
		logic clear;
	} tail_ctl_t;

endpackage

// File: hdl/ipd_ram.sv
module ipd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/ipd_tail.sv
module ipd_tail (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ipd_pkg::BYTE_W-1:0] rx_byte,
	input  ipd_pkg::tail_ctl_t        ctl,
	output logic                      match
);

	logic [ipd_pkg::TAIL_W-1:0]     tail_q;
	logic [ipd_pkg::TAIL_CNT_W-1:0] cnt_q;
	logic [ipd_pkg::TAIL_W-1:0]     tail_nxt;
	logic [ipd_pkg::TAIL_CNT_W-1:0] cnt_nxt;

	// Shift in the new byte and saturate the count
	assign tail_nxt = {tail_q[ipd_pkg::TAIL_W-ipd_pkg::BYTE_W-1:0], rx_byte};
	assign cnt_nxt  = (cnt_q == ipd_pkg::TAIL_CNT_W'(ipd_pkg::TAIL_BYTES)) ?
		cnt_q : cnt_q + 1'b1;

	// Compare the updated history against the markers
	always_comb begin
		match = 1'b0;
		if (cnt_nxt >= ipd_pkg::TAIL_CNT_W'(7) &&
			tail_nxt == ipd_pkg::MARK_CONNECT) begin
			match = 1'b1;
		end
		if (cnt_nxt >= ipd_pkg::TAIL_CNT_W'(6) &&
			tail_nxt[6*ipd_pkg::BYTE_W-1:0] == ipd_pkg::MARK_CLOSED) begin
			match = 1'b1;
		end
		if (cnt_nxt >= ipd_pkg::TAIL_CNT_W'(4) &&
			tail_nxt[4*ipd_pkg::BYTE_W-1:0] == ipd_pkg::MARK_IPD) begin
			match = 1'b1;
		end
	end

	// Update or clear the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.clear) begin
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.shift) begin
			tail_q <= tail_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

endmodule

// File: hdl/ipd_frame_extractor.sv
// Input: one item accepted per cycle while no packet is being flushed.
// A ';' in packet read mode starts a flush: each stored byte is read from memory
// (S_RD), then loaded into the output register (S_LD), where the load waits
// while the output is stalled; an empty packet loads one result via S_EMPTY.
// The input is held until the flush has loaded its last result.
// Reset clears the hunt mode, fill count, tail history and handshakes;
// store contents are not cleared and are only read after being written.
module ipd_frame_extractor #(
	parameter int BUF_DEPTH = ipd_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] payload_byte
	output logic       m_tlast,  // last
	output logic       m_tuser   // [0] empty_packet
);

	localparam int AW = $clog2(BUF_DEPTH);

	ipd_pkg::hunt_mode_t hunt_q;
	ipd_pkg::seq_state_t st_q;
	logic [AW-1:0]       fill_q;
	logic [AW-1:0]       rd_cnt_q;
	logic [AW-1:0]       flush_last_q;
	logic                acc;
	logic                in_read;
	logic                is_semi;
	logic                full;
	logic                match;
	logic                store_clr;
	logic [AW-1:0]       fill_new;
	logic                can_load;
	logic                rd_last;
	logic [7:0]          ram_rdata;
	ipd_pkg::tail_ctl_t  tail_ctl;
	logic                m_tvalid_q;
	logic [7:0]          m_tdata_q;
	logic                m_tlast_q;
	logic                m_tuser_q;

	assign s_tready = (st_q == ipd_pkg::S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_read  = (hunt_q == ipd_pkg::H_READ);
	assign is_semi  = (s_tdata == ipd_pkg::CH_SEMI);
	assign full     = (fill_q == AW'(BUF_DEPTH - 1));
	assign store_clr = match || full;
	assign fill_new = store_clr ? '0 : fill_q + 1'b1;
	assign can_load = !m_tvalid_q || m_tready;
	assign rd_last  = (rd_cnt_q == flush_last_q);

	// Tail history control
	always_comb begin
		tail_ctl.shift = acc && in_read;
		tail_ctl.clear = acc && (((hunt_q == ipd_pkg::H_D) && (s_tdata == ipd_pkg::CH_D)) ||
			(in_read && (store_clr || is_semi)));
	end

	ipd_tail u_tail (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (s_tdata),
		.ctl     (tail_ctl),
		.match   (match)
	);

	ipd_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (tail_ctl.shift),
		.waddr (fill_q),
		.wdata (s_tdata),
		.re    (st_q == ipd_pkg::S_RD),
		.raddr (rd_cnt_q),
		.rdata (ram_rdata)
	);

	// Hunt the prefix and track the fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q <= ipd_pkg::H_PLUS;
			fill_q <= '0;
		end else if (acc) begin
			unique case (hunt_q)
				ipd_pkg::H_PLUS: begin
					hunt_q <= (s_tdata == ipd_pkg::CH_PLUS) ? ipd_pkg::H_I : ipd_pkg::H_PLUS;
				end
				ipd_pkg::H_I: begin
					hunt_q <= (s_tdata == ipd_pkg::CH_I) ? ipd_pkg::H_P : ipd_pkg::H_PLUS;
				end
				ipd_pkg::H_P: begin
					hunt_q <= (s_tdata == ipd_pkg::CH_P) ? ipd_pkg::H_D : ipd_pkg::H_PLUS;
				end
				ipd_pkg::H_D: begin
					if (s_tdata == ipd_pkg::CH_D) begin
						hunt_q <= ipd_pkg::H_READ;
						fill_q <= '0;
					end else begin
						hunt_q <= ipd_pkg::H_PLUS;
					end
				end
				ipd_pkg::H_READ: begin
					if (is_semi) begin
						hunt_q <= ipd_pkg::H_PLUS;
						fill_q <= '0;
					end else begin
						fill_q <= fill_new;
					end
				end
				default: begin
					hunt_q <= ipd_pkg::H_PLUS;
				end
			endcase
		end
	end

	// Sequence the flush: read one entry, then load it into the output; an empty packet loads a single marker result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ipd_pkg::S_IDLE;
			rd_cnt_q     <= '0;
			flush_last_q <= '0;
		end else begin
			unique case (st_q)
				ipd_pkg::S_IDLE: begin
					if (acc && in_read && is_semi) begin
						rd_cnt_q     <= '0;
						flush_last_q <= fill_new - 1'b1;
						st_q         <= (fill_new == '0) ? ipd_pkg::S_EMPTY : ipd_pkg::S_RD;
					end
				end
				ipd_pkg::S_RD: begin
					st_q <= ipd_pkg::S_LD;
				end
				ipd_pkg::S_LD: begin
					if (can_load) begin
						if (rd_last) begin
							st_q <= ipd_pkg::S_IDLE;
						end else begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
							st_q     <= ipd_pkg::S_RD;
						end
					end
				end
				ipd_pkg::S_EMPTY: begin
					if (can_load) begin
						st_q <= ipd_pkg::S_IDLE;
					end
				end
				default: begin
					st_q <= ipd_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (can_load && (st_q == ipd_pkg::S_LD || st_q == ipd_pkg::S_EMPTY)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && st_q == ipd_pkg::S_LD) begin
			m_tdata_q <= ram_rdata;
			m_tlast_q <= rd_last;
			m_tuser_q <= 1'b0;
		end else if (can_load && st_q == ipd_pkg::S_EMPTY) begin
			m_tdata_q <= '0;
			m_tlast_q <= 1'b1;
			m_tuser_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("empty packet result without last");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ipd_pkg::S_LD) |-> (rd_cnt_q <= flush_last_q))
		else $error("flush read beyond packet end");

	a_fill_below_depth: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (32'(fill_q) < BUF_DEPTH))
		else $error("fill count reached store depth");

	a_flush_after_semi: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_read && is_semi) |=> !s_tready)
		else $error("terminator did not start a flush");
`endif

endmodule

// File: tb/tb_ipd_frame_extractor.sv
`timescale 1ns / 100ps

module tb_ipd_frame_extractor;

	localparam int STORE_DEPTH  = ipd_pkg::BUF_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 155;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 16;

	// One packet result as it leaves the block
	typedef struct {
		logic [7:0] payload;
		logic       last;
		logic       empty;
	} payload_res_t;

	// One line of the directed table; typed rows carry their own single result
	typedef struct {
		logic [7:0]   rx;
		int           reps;
		bit           typed;
		payload_res_t res;
	} dir_row_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	// Predictor state
	ipd_pkg::hunt_mode_t        mode_m;
	logic [7:0]                 store_m [STORE_DEPTH];
	int                         fill_m;
	logic [ipd_pkg::TAIL_W-1:0] tail_m;
	int                         tvalid_m;

	payload_res_t step_out[$];
	payload_res_t pending_payload[$];
	dir_row_t     dir_rows[$];

	bit calm;
	int err_cnt       = 0;
	int items_sent;
	int bytes_checked = 0;
	int empty_seen    = 0;
	int packets_sent;
	int cycles        = 0;

	ipd_frame_extractor #(
		.BUF_DEPTH(STORE_DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, pending_payload.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void drop_store();
		fill_m   = 0;
		tail_m   = '0;
		tvalid_m = 0;
	endfunction

	// Advance the predictor by one received byte; results land in step_out
	function automatic void extract_step(input logic [7:0] ch);
		bit hit;
		payload_res_t r;
		step_out.delete();
		if (mode_m != ipd_pkg::H_READ) begin
			if (mode_m == ipd_pkg::H_PLUS && ch == ipd_pkg::CH_PLUS)
				mode_m = ipd_pkg::H_I;
			else if (mode_m == ipd_pkg::H_I && ch == ipd_pkg::CH_I)
				mode_m = ipd_pkg::H_P;
			else if (mode_m == ipd_pkg::H_P && ch == ipd_pkg::CH_P)
				mode_m = ipd_pkg::H_D;
			else if (mode_m == ipd_pkg::H_D && ch == ipd_pkg::CH_D) begin
				mode_m = ipd_pkg::H_READ;
				drop_store();
			end else
				mode_m = ipd_pkg::H_PLUS;
			return;
		end

		// store, then look for a clearing marker among bytes since the last clear
		if (fill_m < STORE_DEPTH)
			store_m[fill_m] = ch;
		fill_m++;
		tail_m = {tail_m[ipd_pkg::TAIL_W-9:0], ch};
		if (tvalid_m < ipd_pkg::TAIL_BYTES)
			tvalid_m++;
		hit = (tvalid_m >= 7 && tail_m == ipd_pkg::MARK_CONNECT) ||
			(tvalid_m >= 6 && tail_m[47:0] == ipd_pkg::MARK_CLOSED) ||
			(tvalid_m >= 4 && tail_m[31:0] == ipd_pkg::MARK_IPD);
		if (hit)
			drop_store();
		if (fill_m >= STORE_DEPTH)
			drop_store();

		// flush on terminator
		if (ch == ipd_pkg::CH_SEMI) begin
			if (fill_m == 0) begin
				r.payload = 8'h00;
				r.last    = 1'b1;
				r.empty   = 1'b1;
				step_out.push_back(r);
			end else begin
				for (int k = 0; k < fill_m; k++) begin
					r.payload = store_m[k];
					r.last    = (k + 1 == fill_m);
					r.empty   = 1'b0;
					step_out.push_back(r);
				end
			end
			mode_m = ipd_pkg::H_PLUS;
			drop_store();
		end
	endfunction

	// Offer one item, wait for acceptance, record what it should produce
	task automatic send_rx(input logic [7:0] rx, input bit typed, input payload_res_t t_res);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		extract_step(rx);
		if (typed)
			pending_payload.push_back(t_res);
		else
			foreach (step_out[i])
				pending_payload.push_back(step_out[i]);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		payload_res_t none;
		none = '{8'h00, 1'b0, 1'b0};
		for (int i = 0; i < s.len(); i++)
			send_rx(s[i], 1'b0, none);
	endtask

	function automatic void add_rep(input logic [7:0] rx, input int reps);
		dir_row_t row;
		row.rx    = rx;
		row.reps  = reps;
		row.typed = 1'b0;
		row.res   = '{8'h00, 1'b0, 1'b0};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_rep(s[i], 1);
	endfunction

	function automatic void add_typed(input logic [7:0] rx, input logic [7:0] pay,
		input logic last, input logic empty);
		dir_row_t row;
		row.rx    = rx;
		row.reps  = 1;
		row.typed = 1'b1;
		row.res   = '{pay, last, empty};
		dir_rows.push_back(row);
	endfunction

	// Receiver: bursts of ready with random stalls
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		payload_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_payload.size() == 0) begin
				$error("unexpected result: payload_byte %02h last %0b empty_packet %0b",
					m_tdata, m_tlast, m_tuser);
				err_cnt++;
			end else begin
				e = pending_payload.pop_front();
				if (m_tdata !== e.payload) begin
					$error("payload_byte: expected %02h, got %02h", e.payload, m_tdata);
					err_cnt++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, m_tlast);
					err_cnt++;
				end
				if (m_tuser !== e.empty) begin
					$error("empty_packet: expected %0b, got %0b", e.empty, m_tuser);
					err_cnt++;
				end
				if (e.empty)
					empty_seen++;
				else
					bytes_checked++;
			end
		end
	end

	initial begin
		int kind;
		int len;
		int r;
		int rand_start;
		payload_res_t none;
		string pfx;

		none          = '{8'h00, 1'b0, 1'b0};
		pfx           = "+IPD";
		calm          = 1'b0;
		items_sent    = 0;
		packets_sent  = 0;
		mode_m        = ipd_pkg::H_PLUS;
		drop_store();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte packet right after reset
		add_text("+IPD");
		add_typed(ipd_pkg::CH_SEMI, ipd_pkg::CH_SEMI, 1'b1, 1'b0);
		// broken prefixes: every byte dropped, terminator ignored in hunt
		add_text("+IX+I+PD;");
		// extreme byte values
		add_text("+IPD");
		add_rep(8'h00, 1);
		add_rep(8'hFF, 1);
		add_rep(ipd_pkg::CH_SEMI, 1);
		// each marker clears the store
		add_text("+IPDxxCONNECTa+IPDbCLOSEDc;");
		// store fills on the terminator itself: empty packet
		add_text("+IPD");
		add_rep(8'h5A, STORE_DEPTH - 1);
		add_typed(ipd_pkg::CH_SEMI, 8'h00, 1'b1, 1'b1);
		// silent wrap, then more bytes
		add_text("+IPD");
		add_rep(8'hA5, STORE_DEPTH + 2);
		add_text("z;");
		// longest packet
		add_text("+IPD");
		add_rep(8'h33, STORE_DEPTH - 2);
		add_rep(ipd_pkg::CH_SEMI, 1);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_rx(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

		// random traffic: mostly framed packets, some noise and broken frames
		rand_start = items_sent;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 5) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 7 || kind == 9) begin
				send_text("+IPD");
				r = $urandom_range(0, 99);
				if (r < 85)
					len = $urandom_range(0, 12);
				else if (r < 95)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(STORE_DEPTH - 8, STORE_DEPTH + 6);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 70)
						send_rx(8'($urandom_range(0, 255)), 1'b0, none);
					else if (r < 88)
						send_rx(8'($urandom_range(8'h20, 8'h7E)), 1'b0, none);
					else begin
						case ($urandom_range(0, 3))
							0: send_text("CONNECT");
							1: send_text("CLOSED");
							2: send_text("+IPD");
							default: send_text("CONNEC");
						endcase
					end
				end
				// an unterminated frame runs into whatever follows
				if (kind != 9) begin
					send_rx(ipd_pkg::CH_SEMI, 1'b0, none);
					packets_sent++;
				end
			end else if (kind == 7) begin
				repeat ($urandom_range(1, 6))
					send_rx(8'($urandom_range(0, 255)), 1'b0, none);
			end else begin
				len = $urandom_range(1, 3);
				send_text(pfx.substr(0, len - 1));
				send_rx(8'($urandom_range(0, 255)), 1'b0, none);
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain outstanding results, then let the block settle
		while (pending_payload.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d random), %0d terminated random frames",
			items_sent, items_sent - rand_start, packets_sent);
		$display("Checked %0d packet bytes and %0d empty packets, %0d mismatches",
			bytes_checked, empty_seen, err_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
